// ===== sv/hawkes_intensity_tracker_assert.svh =====
// Assertion macros for the Hawkes intensity tracker.
// Depends on nothing; included by files that assert.
`ifndef HAWKES_INTENSITY_TRACKER_ASSERT_SVH
`define HAWKES_INTENSITY_TRACKER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HIT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define HIT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/hit_pkg.sv =====
// Shared types and constants for the Hawkes intensity tracker.
// Depends on nothing.
package hit_pkg;

    localparam int MaxProcesses   = 16;
    localparam int MaxBreakpoints = 64;
    localparam int ResultCap      = 16;

    localparam logic [1:0] ModeEvent    = 2'd0;
    localparam logic [1:0] ModeCoupling = 2'd1;
    localparam logic [1:0] ModeBaseline = 2'd2;
    localparam logic [1:0] ModeBreak    = 2'd3;

    localparam logic [1:0] RegProcesses  = 2'd0;
    localparam logic [1:0] RegBreakpoints = 2'd1;
    localparam logic [1:0] RegDecayRate  = 2'd2;

    localparam logic signed [39:0] IntensityMax = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] IntensityMin = -40'sh80_0000_0000;

    // round(2^32 * exp(-2^(k-16)))
    function automatic logic [31:0] exp_bit(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'd4294901760;
            5'd1:  v = 32'd4294836226;
            5'd2:  v = 32'd4294705160;
            5'd3:  v = 32'd4294443040;
            5'd4:  v = 32'd4293918848;
            5'd5:  v = 32'd4292870656;
            5'd6:  v = 32'd4290775039;
            5'd7:  v = 32'd4286586875;
            5'd8:  v = 32'd4278222805;
            5'd9:  v = 32'd4261543595;
            5'd10: v = 32'd4228380000;
            5'd11: v = 32'd4162825044;
            5'd12: v = 32'd4034748382;
            5'd13: v = 32'd3790295335;
            5'd14: v = 32'd3344923893;
            5'd15: v = 32'd2605029347;
            5'd16: v = 32'd1580030169;
            5'd17: v = 32'd581260615;
            5'd18: v = 32'd78665070;
            5'd19: v = 32'd1440801;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_MUL    = 10'b0000000010,
        ST_EXP    = 10'b0000000100,
        ST_SRCH   = 10'b0000001000,
        ST_SREAD  = 10'b0000010000,
        ST_UPD    = 10'b0000100000,
        ST_BASE   = 10'b0001000000,
        ST_MAC    = 10'b0010000000,
        ST_FIN    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

endpackage

// ===== sv/hit_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module hit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/hawkes_intensity_tracker.sv =====
// Hawkes intensity tracker, an exponential-kernel multivariate tracker.
// Depends on hit_pkg, hit_ram and hawkes_intensity_tracker_assert.svh.
//
// Table writes (modes 1 to 3) are taken while idle and return no result.
// Accepting an event registers the decay product; the block then forms the
// decay factor (one exponent bit per cycle) and runs the binary search (each
// breakpoint read waits for the registered RAM read). It then updates the sums
// (one sum register per cycle) and builds each result from a baseline read, NP
// coupling products, rounding and the output beat. NP is the clamped process
// count. The single coupling read port sets the pace of the products. Output
// stalls can hold the output beat, and the input stays stalled until the last
// beat of the event is in the output register.
// Sums live in registers (valid reset), tables in synchronous RAMs.
`include "hawkes_intensity_tracker_assert.svh"
module hawkes_intensity_tracker #(
    parameter int MAX_PROCESSES   = hit_pkg::MaxProcesses,
    parameter int MAX_BREAKPOINTS = hit_pkg::MaxBreakpoints
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [31:0]        event_time,
    input  logic [3:0]         event_process,
    input  logic               first_event,
    input  logic [3:0]         table_row,
    input  logic [5:0]         table_index,
    input  logic signed [23:0] coupling_value,
    input  logic [23:0]        baseline_value,
    input  logic [31:0]        breakpoint_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         process_index,
    output logic [31:0]        decayed_sum,
    output logic signed [39:0] intensity,
    output logic               last
);
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int BW = $clog2(MAX_BREAKPOINTS);
    localparam int CD = MAX_PROCESSES * MAX_PROCESSES;
    localparam int BD = MAX_PROCESSES * MAX_BREAKPOINTS;
    localparam int CAW = $clog2(CD);
    localparam int BAW = $clog2(BD);

    hit_pkg::state_t state_reg, state_next;

    logic [4:0]  np_cfg_reg;
    logic [6:0]  nb_cfg_reg;
    logic [23:0] rate_reg;

    logic [31:0] sums_reg [MAX_PROCESSES];
    logic [31:0] prev_time_reg, t_reg;
    logic [3:0]  prev_proc_reg;
    logic [3:0]  credit_reg;
    logic        seen_reg, clear_reg;

    logic [55:0] x_full_reg;
    logic [32:0] acc_reg;
    logic [4:0]  k_reg;
    logic [16:0] f_reg;
    logic [BW:0] lo_reg, hi_reg, mid_reg;
    logic [6:0]  i_reg, j_reg, np_reg;
    logic signed [63:0] mac_reg;
    logic signed [39:0] res_int_reg;
    logic [31:0] res_sum_reg;
    logic [3:0]  res_idx_reg;
    logic        res_last_reg;
    logic        pend_reg;

    // Table RAMs
    logic           cm_we, bl_we, bp_we;
    logic [CAW-1:0] cm_waddr, cm_raddr;
    logic [BAW-1:0] bl_waddr, bl_raddr;
    logic [BW-1:0]  bp_waddr, bp_raddr;
    logic [23:0]    cm_rdata, bl_rdata;
    logic [31:0]    bp_rdata;

    hit_ram #(.WIDTH(24), .DEPTH(CD)) u_cm (
        .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(coupling_value),
        .raddr(cm_raddr), .rdata(cm_rdata));
    hit_ram #(.WIDTH(24), .DEPTH(BD)) u_bl (
        .clk(clk), .we(bl_we), .waddr(bl_waddr), .wdata(baseline_value),
        .raddr(bl_raddr), .rdata(bl_rdata));
    hit_ram #(.WIDTH(32), .DEPTH(MAX_BREAKPOINTS)) u_bp (
        .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(breakpoint_time),
        .raddr(bp_raddr), .rdata(bp_rdata));

    logic in_acc;
    assign in_stall  = (state_reg != hit_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == hit_pkg::ST_IDLE);

    // Table writes, ignored out of range
    assign cm_we = in_acc && (mode == hit_pkg::ModeCoupling)
                   && (32'(table_row) < MAX_PROCESSES)
                   && (32'(table_index) < MAX_PROCESSES);
    assign bl_we = in_acc && (mode == hit_pkg::ModeBaseline)
                   && (32'(table_row) < MAX_PROCESSES)
                   && (32'(table_index) < MAX_BREAKPOINTS);
    assign bp_we = in_acc && (mode == hit_pkg::ModeBreak)
                   && (32'(table_index) < MAX_BREAKPOINTS);
    assign cm_waddr = CAW'(32'(table_row) * MAX_PROCESSES + 32'(table_index));
    assign bl_waddr = BAW'(32'(table_row) * MAX_BREAKPOINTS + 32'(table_index));
    assign bp_waddr = BW'(table_index);

    // Read addresses
    logic [BW:0] seg;
    assign seg      = lo_reg;
    assign bp_raddr = BW'(mid_reg);
    assign cm_raddr = CAW'(32'(i_reg) * MAX_PROCESSES + 32'(j_reg));
    assign bl_raddr = BAW'(32'(i_reg) * MAX_BREAKPOINTS + 32'(seg));

    // Clamped counts
    logic [6:0] np_clamp;
    logic [6:0] nb_clamp;
    always_comb
    begin
        np_clamp = 7'(np_cfg_reg);
        if (np_clamp < 7'd1) np_clamp = 7'd1;
        if (32'(np_clamp) > MAX_PROCESSES) np_clamp = 7'(MAX_PROCESSES);
        if (32'(np_clamp) > hit_pkg::ResultCap) np_clamp = 7'(hit_pkg::ResultCap);
        nb_clamp = nb_cfg_reg;
        if (nb_clamp < 7'd1) nb_clamp = 7'd1;
        if (32'(nb_clamp) > MAX_BREAKPOINTS) nb_clamp = 7'(MAX_BREAKPOINTS);
    end

    // Datapath pieces
    logic [64:0] exp_prod;
    logic [32:0] acc_step;
    logic [31:0] dt;
    logic [48:0] upd_prod;
    logic [33:0] upd_sum;
    logic signed [56:0] cm_prod;
    logic signed [63:0] rnd;
    logic [PW-1:0] iw;
    assign iw       = PW'(i_reg);
    assign dt       = (event_time >= prev_time_reg) ? event_time - prev_time_reg : 32'd0;
    assign exp_prod = 65'(acc_reg) * 65'(hit_pkg::exp_bit(k_reg)) + 65'h8000_0000;
    assign acc_step = x_full_reg[16 + k_reg] ? exp_prod[64:32] : acc_reg;
    assign upd_prod = 49'(f_reg) * 49'(sums_reg[iw]) + 49'h8000;
    assign upd_sum  = 34'(upd_prod[48:16])
                      + ((i_reg[3:0] == credit_reg) ? 34'(f_reg) : 34'd0);
    assign cm_prod  = 57'(signed'(cm_rdata)) * 57'(signed'({1'b0, sums_reg[PW'(j_reg - 7'd1)]}));
    assign rnd      = (mac_reg + 64'sd32768) >>> 16;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hit_pkg::ST_IDLE:  if (in_acc && mode == hit_pkg::ModeEvent)
                                   state_next = hit_pkg::ST_MUL;
            hit_pkg::ST_MUL:   state_next = hit_pkg::ST_EXP;
            hit_pkg::ST_EXP:   if (k_reg == 5'd19) state_next = hit_pkg::ST_SRCH;
            hit_pkg::ST_SRCH:  state_next = (hi_reg - lo_reg > 1) ? hit_pkg::ST_SREAD
                                                                   : hit_pkg::ST_UPD;
            hit_pkg::ST_SREAD: state_next = hit_pkg::ST_SRCH;
            hit_pkg::ST_UPD:   if (i_reg + 7'd1 >= np_reg) state_next = hit_pkg::ST_BASE;
            hit_pkg::ST_BASE:  state_next = hit_pkg::ST_MAC;
            hit_pkg::ST_MAC:   if (j_reg == np_reg) state_next = hit_pkg::ST_FIN;
            hit_pkg::ST_FIN:   state_next = hit_pkg::ST_OUT;
            hit_pkg::ST_OUT:   if (!pend_reg || !out_stall)
                                   state_next = res_last_reg ? hit_pkg::ST_IDLE
                                                             : hit_pkg::ST_BASE;
            default:           state_next = hit_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hit_pkg::ST_IDLE;
            np_cfg_reg    <= 5'd16;
            nb_cfg_reg    <= 7'd64;
            rate_reg      <= 24'd65536;
            prev_time_reg <= '0;
            prev_proc_reg <= '0;
            seen_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            for (int n = 0; n < MAX_PROCESSES; n++)
            begin
                sums_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == hit_pkg::RegProcesses)   np_cfg_reg <= cfg_data[4:0];
                if (cfg_index == hit_pkg::RegBreakpoints) nb_cfg_reg <= cfg_data[6:0];
                if (cfg_index == hit_pkg::RegDecayRate)   rate_reg   <= cfg_data;
            end
            // Drop the taken beat unless a new one replaces it below
            if (pend_reg && !out_stall && state_reg != hit_pkg::ST_OUT)
            begin
                pend_reg <= 1'b0;
            end
            unique case (state_reg)
                hit_pkg::ST_IDLE:
                begin
                    if (in_acc && mode == hit_pkg::ModeEvent)
                    begin
                        x_full_reg    <= 56'(rate_reg) * 56'(dt);
                        clear_reg     <= first_event || !seen_reg;
                        seen_reg      <= 1'b1;
                        prev_time_reg <= event_time;
                        prev_proc_reg <= event_process;
                        credit_reg    <= prev_proc_reg;
                        t_reg         <= event_time;
                        np_reg        <= np_clamp;
                        lo_reg        <= '0;
                        hi_reg        <= (BW+1)'(nb_clamp - 7'd1);
                        // Sequence start clears every sum, active or not
                        if (first_event || !seen_reg)
                        begin
                            for (int n = 0; n < MAX_PROCESSES; n++)
                            begin
                                sums_reg[n] <= '0;
                            end
                        end
                    end
                end
                hit_pkg::ST_MUL:
                begin
                    acc_reg <= 33'h1_0000_0000;
                    k_reg   <= '0;
                    i_reg   <= '0;
                end
                hit_pkg::ST_EXP:
                begin
                    acc_reg <= acc_step;
                    k_reg   <= k_reg + 5'd1;
                    if (k_reg == 5'd19)
                    begin
                        f_reg <= (x_full_reg[55:16] >= 40'h10_0000) ? 17'd0
                                 : 17'((34'(acc_step) + 34'h8000) >> 16);
                    end
                    mid_reg <= lo_reg + ((hi_reg - lo_reg) >> 1);
                end
                hit_pkg::ST_SRCH:
                begin
                    // mid address presented; data valid next cycle
                end
                hit_pkg::ST_SREAD:
                begin
                    if (bp_rdata <= t_reg)
                    begin
                        lo_reg  <= mid_reg;
                        mid_reg <= mid_reg + ((hi_reg - mid_reg) >> 1);
                    end
                    else
                    begin
                        hi_reg  <= mid_reg;
                        mid_reg <= lo_reg + ((mid_reg - lo_reg) >> 1);
                    end
                end
                hit_pkg::ST_UPD:
                begin
                    // Decay one sum per cycle; cleared sums stay zero
                    if (!clear_reg)
                        sums_reg[iw] <= (upd_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : upd_sum[31:0];
                    if (i_reg + 7'd1 >= np_reg)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 7'd1;
                    end
                end
                hit_pkg::ST_BASE:
                begin
                    j_reg <= j_reg + 7'd1;
                end
                hit_pkg::ST_MAC:
                begin
                    if (j_reg == 7'd1)
                        mac_reg <= 64'(signed'({1'b0, bl_rdata, 16'd0})) + 64'(cm_prod);
                    else
                        mac_reg <= mac_reg + 64'(cm_prod);
                    if (j_reg != np_reg) j_reg <= j_reg + 7'd1;
                end
                hit_pkg::ST_FIN:
                begin
                    res_int_reg  <= (rnd > 64'(hit_pkg::IntensityMax)) ? hit_pkg::IntensityMax
                                  : (rnd < 64'(hit_pkg::IntensityMin)) ? hit_pkg::IntensityMin
                                  : rnd[39:0];
                    res_sum_reg  <= sums_reg[iw];
                    res_idx_reg  <= i_reg[3:0];
                    res_last_reg <= (i_reg + 7'd1 == np_reg);
                end
                hit_pkg::ST_OUT:
                begin
                    if (!pend_reg || !out_stall)
                    begin
                        pend_reg      <= 1'b1;
                        process_index <= res_idx_reg;
                        decayed_sum   <= res_sum_reg;
                        intensity     <= res_int_reg;
                        last          <= res_last_reg;
                        i_reg         <= i_reg + 7'd1;
                        j_reg         <= '0;
                    end
                    else if (pend_reg && !out_stall)
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = pend_reg;

    `HIT_ASSERT_IMP(a_stall_busy, clk, rst_n, in_valid && state_reg != hit_pkg::ST_IDLE, in_stall, "input taken while busy")
    `HIT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(intensity), "stalled beat changed")
    `HIT_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid, 7'(process_index) < np_reg, "result index out of range")
endmodule

// ===== test/tb_hawkes_intensity_tracker.sv =====
// Self-checking testbench for hawkes_intensity_tracker: table loads, events, register phases.
// Depends on hit_pkg and the tracker RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 100ps
module tb_hawkes_intensity_tracker;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] t;
        logic [3:0]  proc;
        logic        first;
        logic [3:0]  row;
        logic [5:0]  idx;
        logic [23:0] cv;
        logic [23:0] bv;
        logic [31:0] bt;
    } item_t;

    typedef struct {
        logic [3:0]  pidx;
        logic [31:0] sum;
        logic [39:0] inten;
        logic        lst;
    } result_t;

    // Scoreboard: own copy of tables, sums and registers; queue of expected beats
    class hawkes_scoreboard;
        logic [23:0] coup [16][16];
        logic [23:0] base [16][64];
        logic [31:0] bps [64];
        logic [31:0] sums [16];
        logic [31:0] prev_t;
        logic [3:0]  prev_p;
        bit          seen;
        logic [4:0]  np_reg;
        logic [6:0]  nb_reg;
        logic [23:0] rate_reg;
        result_t     expected_results [$];
        int          errors;

        function new();
            np_reg = 5'd16;
            nb_reg = 7'd64;
            rate_reg = 24'd65536;
            seen = 0;
            prev_t = 0;
            prev_p = 0;
            errors = 0;
            foreach (sums[i]) sums[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                hit_pkg::RegProcesses:   np_reg = data[4:0];
                hit_pkg::RegBreakpoints: nb_reg = data[6:0];
                hit_pkg::RegDecayRate:   rate_reg = data;
                default: ;
            endcase
        endfunction

        // Kernel weight exp(-x), x in Q.16, result Q1.16
        function logic [16:0] kernel_weight(logic [63:0] x);
            logic [31:0] e [20];
            logic [63:0] acc;
            e = '{32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
                  32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
                  32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
                  32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
                  32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801};
            acc = 64'd1 << 32;
            if (x >= (64'd16 << 16))
                return 17'd0;
            for (int k = 0; k < 20; k++)
                if (x[k])
                    acc = (acc * {32'd0, e[k]} + 64'h8000_0000) >> 32;
            return 17'((acc + 64'h8000) >> 16);
        endfunction

        function void note_beat(item_t it);
            int np, nb, lo, hi, mid, seg;
            logic [63:0] dt, s;
            logic [16:0] f;
            longint acc, v;
            result_t r;
            case (it.mode)
                hit_pkg::ModeCoupling: if (it.idx < 16) coup[it.row][it.idx[3:0]] = it.cv;
                hit_pkg::ModeBaseline: base[it.row][it.idx] = it.bv;
                hit_pkg::ModeBreak:    bps[it.idx] = it.bt;
                default:
                begin
                    np = (np_reg < 1) ? 1 : (np_reg > 16) ? 16 : int'(np_reg);
                    nb = (nb_reg < 1) ? 1 : (nb_reg > 64) ? 64 : int'(nb_reg);
                    // clear on sequence start, else decay and credit the previous process
                    if (it.first || !seen)
                        foreach (sums[i]) sums[i] = 0;
                    else
                    begin
                        dt = (it.t >= prev_t) ? 64'(it.t - prev_t) : 64'd0;
                        f = kernel_weight((64'(rate_reg) * dt) >> 16);
                        for (int i = 0; i < np; i++)
                        begin
                            s = (64'(f) * 64'(sums[i]) + 64'h8000) >> 16;
                            if (i == prev_p)
                                s += 64'(f);
                            sums[i] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
                        end
                    end
                    seen = 1;
                    prev_t = it.t;
                    prev_p = it.proc;
                    // segment search
                    lo = 0;
                    hi = nb - 1;
                    while (hi - lo > 1)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (bps[mid] <= it.t)
                            lo = mid;
                        else
                            hi = mid;
                    end
                    seg = lo;
                    for (int i = 0; i < np; i++)
                    begin
                        acc = longint'(base[i][seg]) <<< 16;
                        for (int j = 0; j < np; j++)
                            acc += longint'($signed(coup[i][j])) * longint'(sums[j]);
                        v = (acc + 32768) >>> 16;
                        if (v > 64'sd549755813887)
                            v = 64'sd549755813887;
                        if (v < -64'sd549755813888)
                            v = -64'sd549755813888;
                        r.pidx = i[3:0];
                        r.sum = sums[i];
                        r.inten = v[39:0];
                        r.lst = (i == np - 1);
                        expected_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void check_beat(result_t got);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: process_index %0d", got.pidx);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.pidx !== exp_r.pidx)
            begin
                $error("process_index: expected %0d, got %0d", exp_r.pidx, got.pidx);
                errors++;
            end
            if (got.sum !== exp_r.sum)
            begin
                $error("decayed_sum: expected %0h, got %0h", exp_r.sum, got.sum);
                errors++;
            end
            if (got.inten !== exp_r.inten)
            begin
                $error("intensity: expected %0h, got %0h", exp_r.inten, got.inten);
                errors++;
            end
            if (got.lst !== exp_r.lst)
            begin
                $error("last: expected %0b, got %0b", exp_r.lst, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [31:0]        event_time;
    logic [3:0]         event_process;
    logic               first_event;
    logic [3:0]         table_row;
    logic [5:0]         table_index;
    logic signed [23:0] coupling_value;
    logic [23:0]        baseline_value;
    logic [31:0]        breakpoint_time;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         process_index;
    logic [31:0]        decayed_sum;
    logic signed [39:0] intensity;
    logic               last;

    hawkes_scoreboard sb = new();
    int  burst_left;
    bit  gaps_on;
    bit  hold_req;
    bit  hold_done;
    logic [31:0] seq_time;

    hawkes_intensity_tracker dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Note accepted input beats and check accepted result beats
    always @(posedge clk)
    begin
        item_t   it;
        result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            it = '{mode, event_time, event_process, first_event, table_row, table_index,
                   coupling_value, baseline_value, breakpoint_time};
            sb.note_beat(it);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r = '{process_index, decayed_sum, intensity, last};
            sb.check_beat(r);
        end
    end

    // Receiver: shifting stall patterns plus one long hold-off on request
    initial
    begin
        int cnt;
        cnt = 0;
        out_stall <= 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cnt++;
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                out_stall <= 1;
                repeat (2500) @(posedge clk);
                out_stall <= 0;
            end
            else
                case (cnt[9:8])
                    2'd0: out_stall <= 0;
                    2'd1: out_stall <= ($urandom_range(0, 2) == 0);
                    2'd2: out_stall <= cnt[2];
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
        end
    end

    function automatic item_t rand_item();
        item_t it;
        it.mode = 2'($urandom_range(0, 3));
        it.t = $urandom;
        it.proc = 4'($urandom_range(0, 15));
        it.first = 1'($urandom_range(0, 1));
        it.row = 4'($urandom_range(0, 15));
        it.idx = 6'($urandom_range(0, 63));
        it.cv = 24'($urandom);
        it.bv = 24'($urandom);
        it.bt = $urandom;
        return it;
    endfunction

    // Send one beat; with gaps on, the sender idles between bursts of random length
    task automatic send_beat(item_t it);
        if (gaps_on && burst_left <= 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1;
        mode <= it.mode;
        event_time <= it.t;
        event_process <= it.proc;
        first_event <= it.first;
        table_row <= it.row;
        table_index <= it.idx;
        coupling_value <= it.cv;
        baseline_value <= it.bv;
        breakpoint_time <= it.bt;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic send_table(logic [1:0] m, logic [3:0] row, logic [5:0] idx,
                              logic [31:0] val);
        item_t it;
        it = rand_item();
        it.mode = m;
        it.row = row;
        it.idx = idx;
        it.cv = val[23:0];
        it.bv = val[23:0];
        it.bt = val;
        send_beat(it);
    endtask

    task automatic send_event(logic [31:0] t, logic [3:0] p, logic first);
        item_t it;
        it = rand_item();
        it.mode = hit_pkg::ModeEvent;
        it.t = t;
        it.proc = p;
        it.first = first;
        send_beat(it);
    endtask

    // Drop valid, wait until all results are in, then let the block settle
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 0;
    endtask

    // Mixed traffic: event sequences with random content, some table rewrites and noise
    task automatic run_traffic(int n);
        logic [5:0] k;
        for (int c = 0; c < n; c++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                k = 6'($urandom_range(0, 63));
                case ($urandom_range(0, 2))
                    0: send_table(hit_pkg::ModeCoupling, 4'($urandom_range(0, 3)),
                                  6'($urandom_range(0, 19)), $urandom);
                    1: send_table(hit_pkg::ModeBaseline, 4'($urandom_range(0, 3)), k, $urandom);
                    default: send_table(hit_pkg::ModeBreak, 4'd0, k,
                                        {k[2:0], 29'($urandom)});
                endcase
            end
            if (c == 0 || $urandom_range(0, 7) == 0)
            begin
                seq_time = $urandom;
                send_event(seq_time, 4'($urandom_range(0, 15)), 1'b1);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: seq_time = seq_time + $urandom;
                    2: seq_time = seq_time - $urandom_range(1, 1 << 20);
                    default: seq_time = seq_time + $urandom_range(0, 1 << 18);
                endcase
                send_event(seq_time, 4'($urandom_range(0, 15)), 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_valid <= 0;
        cfg_index <= hit_pkg::RegProcesses;
        cfg_data <= 0;
        in_valid <= 0;
        mode <= hit_pkg::ModeEvent;
        event_time <= 0;
        event_process <= 0;
        first_event <= 0;
        table_row <= 0;
        table_index <= 0;
        coupling_value <= 0;
        baseline_value <= 0;
        breakpoint_time <= 0;
        burst_left = 0;
        gaps_on = 1;
        hold_req = 0;
        hold_done = 0;
        seq_time = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Keep to four processes and eight breakpoints so the loads stay short
        write_reg(hit_pkg::RegProcesses, 24'd4);
        write_reg(hit_pkg::RegBreakpoints, 24'd8);

        // Load every entry in use so no event reads an unwritten one
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_table(hit_pkg::ModeCoupling, 4'(r), 6'(c), $urandom);
        for (int r = 0; r < 4; r++)
            for (int s = 0; s < 8; s++)
                send_table(hit_pkg::ModeBaseline, 4'(r), 6'(s), $urandom);
        for (int s = 0; s < 8; s++)
            send_table(hit_pkg::ModeBreak, 4'd0, 6'(s),
                       (s == 0) ? 32'd0 : (s == 7) ? 32'hFFFF_FFFF :
                       {3'(s), 29'($urandom)});

        // Directed: field extremes, sequence starts, backwards time, ignored writes
        send_table(hit_pkg::ModeCoupling, 4'd0, 6'd0, 32'h80_0000);
        send_table(hit_pkg::ModeCoupling, 4'd3, 6'd3, 32'h7F_FFFF);
        send_table(hit_pkg::ModeCoupling, 4'd3, 6'd40, 32'h12_3456);
        send_table(hit_pkg::ModeBaseline, 4'd0, 6'd7, 32'hFF_FFFF);
        send_table(hit_pkg::ModeBaseline, 4'd3, 6'd0, 32'h0);
        send_event(32'd0, 4'd0, 1'b0);
        send_event(32'd0, 4'd15, 1'b0);
        send_event(32'd65536, 4'd3, 1'b0);
        send_event(32'd40000, 4'd3, 1'b0);
        send_event(32'hFFFF_FFFF, 4'd2, 1'b0);
        send_event(32'h8000_0000, 4'd1, 1'b1);
        send_event(32'h8000_1000, 4'd1, 1'b0);
        send_event(32'h8000_1000, 4'd2, 1'b0);
        drain();

        // Register phases, extremes among them
        write_reg(hit_pkg::RegProcesses, 24'd3);
        write_reg(hit_pkg::RegBreakpoints, 24'd1);
        write_reg(hit_pkg::RegDecayRate, 24'd0);
        send_event(32'h100, 4'd15, 1'b0);
        send_event(32'h200, 4'd2, 1'b0);
        send_event(32'h300, 4'd0, 1'b0);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd4);
        write_reg(hit_pkg::RegBreakpoints, 24'd8);
        write_reg(hit_pkg::RegDecayRate, 24'hFF_FFFF);
        hold_req = 1;
        run_traffic(15);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd0);
        write_reg(hit_pkg::RegBreakpoints, 24'd0);
        write_reg(hit_pkg::RegDecayRate, 24'd65536);
        run_traffic(15);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd4);
        write_reg(hit_pkg::RegBreakpoints, 24'd2);
        write_reg(hit_pkg::RegDecayRate, 24'd1000);
        gaps_on = 0;
        run_traffic(15);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd2);
        write_reg(hit_pkg::RegBreakpoints, 24'd5);
        write_reg(hit_pkg::RegDecayRate, 24'd300000);
        gaps_on = 1;
        run_traffic(15);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd1);
        write_reg(hit_pkg::RegBreakpoints, 24'd7);
        write_reg(hit_pkg::RegDecayRate, 24'd20000);
        run_traffic(15);
        drain();

        write_reg(hit_pkg::RegProcesses, 24'd4);
        write_reg(hit_pkg::RegBreakpoints, 24'd8);
        write_reg(hit_pkg::RegDecayRate, 24'd65536);
        run_traffic(15);
        drain();

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hit_pkg.sv
sv/hit_ram.sv
sv/hawkes_intensity_tracker.sv
test/tb_hawkes_intensity_tracker.sv
